[rtl/uhl_pkg.sv]
// Package for the unique handle list: sizes, codes and the item and chain types.
package uhl_pkg;

    localparam int DEPTH        = 16;
    localparam int HANDLE_WIDTH = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int CAP_W        = 5;
    localparam int CMP_W        = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_PRESENT  = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_ABSENT   = 3'd3;
    localparam logic [2:0] STAT_BADINDEX = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] handle;
        logic [7:0]  position;
    } uhl_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_handle;
        logic [4:0]  count;
    } uhl_out_t;

    // The probe that walks the chain, one cell per cycle.
    typedef struct packed {
        logic                    valid;
        logic [HANDLE_WIDTH-1:0] key;
        logic [CNT_W-1:0]        left;
        logic [7:0]              pos;
        logic                    hit;
        logic                    got;
        logic                    free_seen;
        logic [HANDLE_WIDTH-1:0] data;
    } uhl_probe_t;

    // Broadcast from the controller once the probe has left the last cell.
    typedef struct packed {
        logic                    append;
        logic                    shift;
        logic [HANDLE_WIDTH-1:0] key;
    } uhl_commit_t;

endpackage

[rtl/unique_handle_list_core.sv]
// Top level of the unique handle list: controller, capacity register and the chain of cells.
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------------
//  command   start high, busy low   command (cmd, handle, position)
//  result    done high, one cycle   result (status, read_handle, count)
//  config    cfg_we high            cfg_wdata (capacity)
//
// Every item sends a probe down the row of DEPTH cells, one cell per cycle, through the
// head register and each cell's register; the result strobe is registered from the last
// cell, and busy drops with it, so the next item can be accepted while it is shown.
// Reset clears the entry count and the controller and sets the capacity to 16; the
// entry storage itself is not cleared. The result is shown for exactly one cycle
// and the receiver cannot stall it; busy stays high while an item is in flight.
module unique_handle_list_core
    import uhl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  uhl_in_t          command,
    output logic             done,
    output uhl_out_t         result,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] capacity_reg;
    logic [1:0]       cmd_reg;
    logic             head_valid_reg;
    uhl_probe_t       head_reg;
    uhl_probe_t       head_probe;
    logic             done_reg;
    uhl_out_t         result_reg;
    uhl_out_t         result_next;
    uhl_commit_t      commit;
    logic             accept;
    logic             finish;
    logic [CMP_W-1:0] cap_eff;
    logic             list_full;

    uhl_probe_t              chain [DEPTH+1];
    logic [HANDLE_WIDTH-1:0] entries [DEPTH];

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    // The probe has passed every cell once the last one hands it back.
    assign finish = (state_reg == S_PROBE) && chain[DEPTH].valid;

    // A capacity above the row length is limited to the row length.
    assign cap_eff   = (CMP_W'(capacity_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                               : CMP_W'(capacity_reg);
    assign list_full = (CMP_W'(count_reg) >= cap_eff);

    // The head of the chain: the probe launched by the accepted item.
    always_comb
    begin
        head_probe       = head_reg;
        head_probe.valid = head_valid_reg;
    end
    assign chain[0] = head_probe;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            uhl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .probe_in   (chain[gi]),
                .probe_out  (chain[gi+1]),
                .commit     (commit),
                .next_entry ((gi == DEPTH - 1) ? entries[gi] : entries[(gi + 1) % DEPTH]),
                .entry      (entries[gi])
            );
        end
    endgenerate

    // Decide the outcome from what the probe collected on its way.
    always_comb
    begin
        commit.append = 1'b0;
        commit.shift  = 1'b0;
        commit.key    = chain[DEPTH].key;
        count_next    = count_reg;
        result_next.status      = STAT_OK;
        result_next.read_handle = 32'd0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (chain[DEPTH].hit)
                begin
                    result_next.status = STAT_PRESENT;
                end
                else if (list_full)
                begin
                    result_next.status = STAT_FULL;
                end
                else
                begin
                    commit.append = finish;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (chain[DEPTH].hit)
                begin
                    commit.shift = finish;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                begin
                    result_next.status = STAT_ABSENT;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                if (chain[DEPTH].got)
                begin
                    result_next.read_handle = 32'(chain[DEPTH].data);
                end
                else
                begin
                    result_next.status = STAT_BADINDEX;
                end
            end
        endcase
        result_next.count = 5'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            capacity_reg   <= CAP_W'(16);
            head_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= accept;
            done_reg       <= finish;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg            <= command.cmd;
            head_reg.key       <= HANDLE_WIDTH'(command.handle);
            head_reg.left      <= count_reg;
            head_reg.pos       <= command.position;
            head_reg.hit       <= 1'b0;
            head_reg.got       <= 1'b0;
            head_reg.free_seen <= 1'b0;
            head_reg.data      <= '0;
            head_reg.valid     <= 1'b1;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/uhl_cell.sv]
// One list cell: holds one entry, inspects the passing probe and takes part in appends and shifts.
module uhl_cell
    import uhl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  uhl_probe_t              probe_in,
    output uhl_probe_t              probe_out,
    input  uhl_commit_t             commit,
    input  logic [HANDLE_WIDTH-1:0] next_entry,
    output logic [HANDLE_WIDTH-1:0] entry
);

    logic [HANDLE_WIDTH-1:0] entry_reg;
    logic                    tail_reg;
    logic                    shift_reg;
    logic                    probe_valid_reg;
    uhl_probe_t              probe_reg;
    uhl_probe_t              probe_next;
    logic                    occupied;
    logic                    match;
    logic                    is_tail;
    logic                    is_target;

    // The cell is occupied while the remaining count seen by the probe is nonzero.
    assign occupied  = (probe_in.left != '0);
    assign match     = occupied && (entry_reg == probe_in.key);
    assign is_tail   = !occupied && !probe_in.free_seen;
    assign is_target = occupied && !probe_in.got && (probe_in.pos == 8'd0);

    always_comb
    begin
        probe_next           = probe_in;
        probe_next.hit       = probe_in.hit | match;
        probe_next.free_seen = probe_in.free_seen | !occupied;
        probe_next.left      = occupied ? (probe_in.left - CNT_W'(1)) : probe_in.left;
        probe_next.pos       = (probe_in.pos != 8'd0) ? (probe_in.pos - 8'd1) : probe_in.pos;
        if (is_target)
        begin
            probe_next.got  = 1'b1;
            probe_next.data = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
            tail_reg        <= 1'b0;
            shift_reg       <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_in.valid;
            if (probe_in.valid)
            begin
                tail_reg  <= is_tail;
                shift_reg <= probe_in.hit | match;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (probe_in.valid)
        begin
            probe_reg <= probe_next;
        end
        if (commit.append && tail_reg)
        begin
            entry_reg <= commit.key;
        end
        else if (commit.shift && shift_reg)
        begin
            entry_reg <= next_entry;
        end
    end

    always_comb
    begin
        probe_out       = probe_reg;
        probe_out.valid = probe_valid_reg;
    end

    assign entry = entry_reg;

endmodule

[tb/sv/tb_unique_handle_list_core.sv]
// Self-checking testbench for the unique handle list core with a built-in list predictor.
module tb_unique_handle_list_core;
    timeunit 1ns;
    timeprecision 1ps;

    import uhl_pkg::*;

    // The watchdog gives up after this many cycles without an accepted item or result.
    // The limit is far above the time one item takes plus the longest sender gap, so this
    // leaves a wide margin over the slowest correct run.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 24;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 62;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    uhl_in_t          command   = '0;
    logic             done;
    uhl_out_t         result;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    unique_handle_list_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Two-delay clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Commands waiting to be driven, and the answers the list should give, oldest first.
    uhl_in_t  cmd_queue[$];
    uhl_out_t list_answers[$];

    // Shadow copy of the list contents, its length and the capacity register.
    logic [HANDLE_WIDTH-1:0] list_entries [DEPTH];
    int                      list_count = 0;
    int                      list_cap   = 16;

    // Handles that random items mostly draw from, so that adds and removes hit each other.
    logic [31:0] handle_pool [POOL_SIZE];
    int          phase_cap   [PHASES];
    int          phase_clear [PHASES];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int gap_left       = 0;
    int burst_left     = 0;

    // Position of a handle in the shadow list, or the list length when it is absent.
    function automatic int find_entry(logic [HANDLE_WIDTH-1:0] h);
        for (int i = 0; i < list_count; i++)
        begin
            if (list_entries[i] == h)
                return i;
        end
        return list_count;
    endfunction

    // Applies one command to the shadow list and returns the answer the core must give.
    function automatic uhl_out_t apply_list_cmd(uhl_in_t c);
        uhl_out_t ans;
        int       limit;
        int       k;
        // A capacity above DEPTH still stops at DEPTH entries.
        limit = (list_cap > DEPTH) ? DEPTH : list_cap;
        ans.status      = STAT_OK;
        ans.read_handle = '0;
        case (c.cmd)
            CMD_ADD:
            begin
                // The duplicate check wins over the full check.
                if (find_entry(c.handle) < list_count)
                    ans.status = STAT_PRESENT;
                else if (list_count >= limit)
                    ans.status = STAT_FULL;
                else
                begin
                    list_entries[list_count] = c.handle;
                    list_count++;
                end
            end
            CMD_REMOVE:
            begin
                k = find_entry(c.handle);
                if (k >= list_count)
                    ans.status = STAT_ABSENT;
                else
                begin
                    // Close the gap by moving every later entry down by one.
                    for (int i = k; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_count--;
                end
            end
            CMD_CLEAR:
                list_count = 0;
            default:
            begin
                if (c.position >= list_count)
                    ans.status = STAT_BADINDEX;
                else
                    ans.read_handle = list_entries[c.position];
            end
        endcase
        ans.count = CAP_W'(list_count);
        return ans;
    endfunction

    // Random command: the clear rate is set per phase, handles come mostly from the
    // pool and positions mostly near the valid range.
    function automatic uhl_in_t random_cmd(int clear_pct);
        uhl_in_t c;
        int      roll;
        roll = $urandom_range(0, 99);
        if (roll < clear_pct)
            c.cmd = CMD_CLEAR;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                c.cmd = CMD_ADD;
            else if (roll < 72)
                c.cmd = CMD_REMOVE;
            else
                c.cmd = CMD_READ;
        end
        if ($urandom_range(0, 9) < 7)
            c.handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            c.handle = $urandom;
        if ($urandom_range(0, 4) != 0)
            c.position = 8'($urandom_range(0, DEPTH + 1));
        else
            c.position = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic queue_cmd(logic [1:0] op, logic [31:0] h, logic [7:0] pos);
        uhl_in_t c;
        c.cmd      = op;
        c.handle   = h;
        c.position = pos;
        cmd_queue.push_back(c);
    endtask

    // Returns at a falling edge once every item has been driven and answered and the
    // core has dropped busy.
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_queue.size() != 0 || list_answers.size() != 0 || start || busy)
            @(negedge clk);
    endtask

    // Writes the capacity register while the core is idle and mirrors it in the shadow.
    task automatic write_capacity(int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        list_cap = value;
        @(negedge clk);
    endtask

    // Driver. An item is taken at an edge where start is high and busy is low; the
    // prediction is made right there so the shadow list follows acceptance order.
    // The sender runs in bursts of random length and idles for a random gap after
    // each burst; a gap of zero gives back-to-back items.
    always @(posedge clk)
    begin
        logic taken;
        taken = rst_n && start && !busy;
        if (taken)
            list_answers.push_back(apply_list_cmd(command));
        if (!rst_n)
            start <= 1'b0;
        else if (!start || taken)
        begin
            // A held item stays on the port untouched until it is taken.
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (cmd_queue.size() != 0)
            begin
                command <= cmd_queue.pop_front();
                start   <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor. The result is valid for the one cycle that done is high and is
    // sampled at the edge that ends it; each one is checked against the oldest answer.
    always @(posedge clk)
    begin
        uhl_out_t want;
        if (rst_n && done)
        begin
            if (list_answers.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d read_handle %h count %0d",
                             result.status, result.read_handle, result.count);
                mismatch_count++;
            end
            else
            begin
                want = list_answers.pop_front();
                if (result.status !== want.status ||
                    result.read_handle !== want.read_handle ||
                    result.count !== want.count)
                begin
                    if (mismatch_count < 10)
                    begin
                        $write("mismatch: expected status %0d read_handle %h count %0d,",
                               want.status, want.read_handle, want.count);
                        $display(" got status %0d read_handle %h count %0d",
                                 result.status, result.read_handle, result.count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog. Any accepted item or result restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        // Random phases: the first sets capacity 31, so adds stop at DEPTH entries, the next
        // lowers the capacity below the count, and the rest sweep the extremes.
        phase_cap   = '{31, 8, 17, 0, 1, 15, 16, 5};
        phase_clear = '{0, 2, 1, 5, 5, 3, 8, 4};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items at the reset capacity of 16: empty list reads and removes,
        // the extreme handles, a duplicate add, reads at and past the end, removal
        // from the front with the shift, and clear.
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd0);
        queue_cmd(CMD_REMOVE, 32'h1234_5678, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0000, 8'hFF);
        queue_cmd(CMD_ADD,    32'hFFFF_FFFF, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0000, 8'd0);
        queue_cmd(CMD_READ,   32'hFFFF_FFFF, 8'd0);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd1);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd2);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'hFF);
        queue_cmd(CMD_REMOVE, 32'h0000_0000, 8'hFF);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd0);
        queue_cmd(CMD_ADD,    32'hA5A5_A5A5, 8'd0);
        queue_cmd(CMD_CLEAR,  32'hFFFF_FFFF, 8'hFF);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd0);
        wait_drained();

        // A small capacity: the list fills, and a present handle still answers present.
        write_capacity(2);
        queue_cmd(CMD_ADD,    32'h0000_0001, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0002, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0003, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0002, 8'd0);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd1);
        wait_drained();

        // Capacity lowered below the count: the entries stay and adds answer full
        // until the count has dropped below the new capacity.
        write_capacity(1);
        queue_cmd(CMD_ADD,    32'h0000_0004, 8'd0);
        queue_cmd(CMD_REMOVE, 32'h0000_0001, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0004, 8'd0);
        queue_cmd(CMD_READ,   32'h0000_0000, 8'd0);
        queue_cmd(CMD_REMOVE, 32'h0000_0002, 8'd0);
        queue_cmd(CMD_ADD,    32'h0000_0004, 8'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_capacity(phase_cap[p]);
            handle_pool[0] = 32'h0000_0000;
            handle_pool[1] = 32'hFFFF_FFFF;
            for (int i = 2; i < POOL_SIZE; i++)
                handle_pool[i] = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++)
                cmd_queue.push_back(random_cmd(phase_clear[p]));
        end

        // Let the last result drain, then allow a few more cycles for stray strobes.
        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatch_count == 0 && list_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
